// File: rtl/talx_pkg.sv
// Shared constants and types for the triple additive lagged Fibonacci generator.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package talx_pkg;

   localparam int LONG_LAG  = 55;
   localparam int SHORT_LAG = 24;
   localparam int LAG_GAP   = LONG_LAG - SHORT_LAG;
   localparam int GEN_COUNT = 3;
   localparam int WORD_W    = 32;
   localparam int IDX_W     = 6;
   localparam int SEL_W     = 2;
   localparam int FRAC_W    = 2 * WORD_W;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_GEN  = 1'b1;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [SEL_W-1:0]  sel_type;
   typedef logic [FRAC_W-1:0] frac_type;

endpackage

`default_nettype wire

// File: rtl/triple_additive_lfg_xor.sv
// Top level: three additive lagged Fibonacci generators (lags 24/55) XORed into
// one 64-bit fraction per generate request. Depends on talx_pkg.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------
//   req     | in        | req_valid/req_stall| req_cmd, req_gen_select, req_slot,
//           |           |                    | req_seed_word
//   rsp     | out       | rsp_valid/rsp_stall| rsp_fraction
//
// A generate request moves from the input register through the table update into
// the result register, and waits in the input register while the result is held.
// One request is taken every cycle while req_stall is low;
// a load never waits on the result side.
// Each table is kept as a rotating register line: position p holds slot
// (ring index + p) mod 55, so both lag steps read fixed taps 0, 1, 31, 32 and
// a generate shifts the line by two places.
// Synchronous active-high reset clears the ring index and all valid flags;
// table contents stay undefined until loaded.
// req_stall rises only when a generate waits in the input register behind a
// result that rsp_stall is holding.
`default_nettype none

module triple_additive_lfg_xor (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire                 req_cmd,
   input  talx_pkg::sel_type   req_gen_select,
   input  talx_pkg::idx_type   req_slot,
   input  talx_pkg::word_type  req_seed_word,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output talx_pkg::frac_type  rsp_fraction
);

   import talx_pkg::*;

   localparam logic [IDX_W:0] LAG_WIDE = (IDX_W+1)'(LONG_LAG);

   // input register
   logic     s1_valid_ff, s1_valid_in;
   logic     s1_cmd_ff;
   sel_type  s1_sel_ff;
   idx_type  s1_slot_ff;
   word_type s1_seed_ff;

   // generator state
   word_type ring_ff [GEN_COUNT][LONG_LAG];
   word_type ring_in [GEN_COUNT][LONG_LAG];
   idx_type  idx_ff, idx_in;

   // result register
   logic     rsp_valid_ff, rsp_valid_in;
   frac_type rsp_frac_ff, rsp_frac_in;

   logic           out_free;
   logic           s1_go;
   logic           req_take;
   logic           do_gen;
   logic           do_load;
   logic [IDX_W:0] pos_wide;
   logic [IDX_W:0] idx_step;
   idx_type        load_pos;
   word_type       sum_lo [GEN_COUNT];
   word_type       sum_hi [GEN_COUNT];
   word_type       step_lo, step_hi;

   // Handshake: loads always drain, generates need a free result register.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_go     = s1_valid_ff && ((s1_cmd_ff == CMD_LOAD) || out_free);
   assign req_stall = s1_valid_ff && !s1_go;
   assign req_take  = req_valid && !req_stall;

   assign do_gen  = s1_go && (s1_cmd_ff == CMD_GEN);
   assign do_load = s1_go && (s1_cmd_ff == CMD_LOAD)
                    && (s1_slot_ff < idx_type'(LONG_LAG))
                    && (s1_sel_ff < sel_type'(GEN_COUNT));

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   // Map a table slot onto its place in the rotating line.
   always_comb begin
      pos_wide = {1'b0, s1_slot_ff} - {1'b0, idx_ff};
      if (s1_slot_ff < idx_ff) begin
         pos_wide = pos_wide + LAG_WIDE;
      end
      load_pos = pos_wide[IDX_W-1:0];
   end

   // Both lag steps read fixed taps of each line.
   always_comb begin
      step_lo = '0;
      step_hi = '0;
      for (int g = 0; g < GEN_COUNT; g++) begin
         sum_lo[g] = ring_ff[g][0] + ring_ff[g][LAG_GAP];
         sum_hi[g] = ring_ff[g][1] + ring_ff[g][LAG_GAP+1];
         step_lo   = step_lo ^ sum_lo[g];
         step_hi   = step_hi ^ sum_hi[g];
      end
   end

   // Advance the lines by two on generate, or drop a seed word in on load.
   always_comb begin
      ring_in = ring_ff;
      if (do_gen) begin
         for (int g = 0; g < GEN_COUNT; g++) begin
            for (int p = 0; p < LONG_LAG - 2; p++) begin
               ring_in[g][p] = ring_ff[g][p+2];
            end
            ring_in[g][LONG_LAG-2] = sum_lo[g];
            ring_in[g][LONG_LAG-1] = sum_hi[g];
         end
      end else if (do_load) begin
         ring_in[s1_sel_ff][load_pos] = s1_seed_ff;
      end
   end

   // Ring index moves by two per generate, wrapping at 55.
   always_comb begin
      idx_step = {1'b0, idx_ff} + (IDX_W+1)'(2);
      if (idx_step >= LAG_WIDE) begin
         idx_step = idx_step - LAG_WIDE;
      end
      idx_in = do_gen ? idx_step[IDX_W-1:0] : idx_ff;
   end

   // Result register: hold while stalled, otherwise take the new fraction.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_frac_in  = rsp_frac_ff;
      if (out_free) begin
         rsp_valid_in = do_gen;
      end
      if (do_gen) begin
         rsp_frac_in = {step_hi, step_lo};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff  <= req_cmd;
         s1_sel_ff  <= req_gen_select;
         s1_slot_ff <= req_slot;
         s1_seed_ff <= req_seed_word;
      end
      ring_ff     <= ring_in;
      rsp_frac_ff <= rsp_frac_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_fraction = rsp_frac_ff;

endmodule

`default_nettype wire

// File: rtl/talx_check.sv
// Port-level checker for triple_additive_lfg_xor, bound to the top level.
// Depends on talx_pkg.
`default_nettype none

module talx_check (
   input wire                 clock,
   input wire                 reset,
   input wire                 req_valid,
   input wire                 req_stall,
   input wire                 req_cmd,
   input wire                 rsp_valid,
   input wire                 rsp_stall,
   input talx_pkg::frac_type  rsp_fraction
);

   import talx_pkg::*;

   // A held result keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_fraction))
      else $error("held result changed");

   // Reset empties the result register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Requests back up only behind a held result.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with free output");

   // A generate reaches an empty result register in the cycle after the input stage.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_cmd == CMD_GEN) ##1 !rsp_valid |=> rsp_valid)
      else $error("generate request lost");

endmodule

bind triple_additive_lfg_xor talx_check u_talx_check (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_cmd      (req_cmd),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_fraction (rsp_fraction)
);

`default_nettype wire

// File: tb/tb_triple_additive_lfg_xor.sv
`timescale 1ns / 100ps
// Self-checking testbench for triple_additive_lfg_xor: seeds the three lag tables,
// runs a directed table and a random request stream against a local predictor.
// Depends on talx_pkg and the triple_additive_lfg_xor top level.

module tb_triple_additive_lfg_xor;
   import talx_pkg::*;

   // Table selects; the last code addresses no table and must be ignored.
   localparam sel_type SEL_ONE   = 2'd0;
   localparam sel_type SEL_TWO   = 2'd1;
   localparam sel_type SEL_THREE = 2'd2;
   localparam sel_type SEL_NONE  = 2'd3;

   localparam int RANDOM_REQUESTS = 1450;
   localparam int QUIET_TAIL      = 200;   // final random requests with no idling
   localparam int PRESSURE_AT     = 600;   // accepted requests before the long hold-off
   localparam int PRESSURE_CYCLES = 80;
   localparam int DRAIN_CYCLES    = 10;    // settle time after the last fraction, with margin

   typedef struct packed {
      logic     cmd;
      sel_type  sel;
      idx_type  slot;
      word_type word;
      logic     typed;      // fraction below is the expected result
      frac_type fraction;
   } stim_row_type;

   // Directed rows. The run seeds every slot with zero first, so the ring index
   // and the table contents at each row are easy to follow by hand.
   localparam int DIRECTED_ROWS = 16;
   localparam stim_row_type DIRECTED_TABLE [DIRECTED_ROWS] = '{
      // all tables zero: fraction is zero, and generate fields are ignored
      '{CMD_GEN,  SEL_NONE,  6'd63, 32'hffff_ffff, 1'b1, 64'h0},
      // bad select, bad slot, largest bad slot: all dropped
      '{CMD_LOAD, SEL_NONE,  6'd2,  32'hffff_ffff, 1'b0, 64'h0},
      '{CMD_LOAD, SEL_ONE,   6'd55, 32'hffff_ffff, 1'b0, 64'h0},
      '{CMD_LOAD, SEL_TWO,   6'd63, 32'hffff_ffff, 1'b0, 64'h0},
      // still zero if the dropped loads left the tables alone
      '{CMD_GEN,  SEL_ONE,   6'd0,  32'h0,         1'b1, 64'h0},
      // index is 4 here: current word and the word 31 slots ahead
      '{CMD_LOAD, SEL_ONE,   6'd4,  32'hffff_ffff, 1'b0, 64'h0},
      '{CMD_LOAD, SEL_TWO,   6'd35, 32'h0000_0001, 1'b0, 64'h0},
      '{CMD_GEN,  SEL_THREE, 6'd54, 32'ha5a5_a5a5, 1'b0, 64'h0},
      // index is 6: sums that carry out of 32 bits and wrap to zero
      '{CMD_LOAD, SEL_ONE,   6'd6,  32'hffff_ffff, 1'b0, 64'h0},
      '{CMD_LOAD, SEL_ONE,   6'd37, 32'h0000_0001, 1'b0, 64'h0},
      '{CMD_LOAD, SEL_THREE, 6'd7,  32'h8000_0000, 1'b0, 64'h0},
      '{CMD_LOAD, SEL_THREE, 6'd38, 32'h8000_0000, 1'b0, 64'h0},
      '{CMD_LOAD, SEL_TWO,   6'd54, 32'hffff_ffff, 1'b0, 64'h0},
      '{CMD_GEN,  SEL_TWO,   6'd31, 32'h1234_5678, 1'b1, 64'h0},
      '{CMD_GEN,  SEL_NONE,  6'd0,  32'h0,         1'b0, 64'h0},
      '{CMD_GEN,  SEL_ONE,   6'd1,  32'hffff_ffff, 1'b0, 64'h0}
   };

   logic     clock;
   logic     reset;
   logic     req_valid;
   logic     req_stall;
   logic     req_cmd;
   sel_type  req_gen_select;
   idx_type  req_slot;
   word_type req_seed_word;
   logic     rsp_valid;
   logic     rsp_stall;
   frac_type rsp_fraction;

   // Predictor state: three lag tables and the shared ring position.
   word_type lag_tables [GEN_COUNT][LONG_LAG];
   idx_type  ring_pos;

   frac_type expected_fractions [$];

   bit quiet_tail;
   bit pressure_on;
   int error_count;
   int accepted_count;
   int load_count;
   int dropped_count;
   int checked_count;

   triple_additive_lfg_xor i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_gen_select (req_gen_select),
      .req_slot       (req_slot),
      .req_seed_word  (req_seed_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_fraction   (rsp_fraction)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // One lag step over all three tables: add the word 31 slots ahead in place,
   // XOR the three new words, advance the ring position with wrap at 55.
   function automatic word_type lag_xor_step();
      int       ahead_sum;
      idx_type  ahead;
      word_type mixed;
      ahead_sum = int'(ring_pos) + LAG_GAP;
      if (ahead_sum >= LONG_LAG) ahead_sum -= LONG_LAG;
      ahead = idx_type'(ahead_sum);
      mixed = '0;
      for (int g = 0; g < GEN_COUNT; g++) begin
         lag_tables[g][ring_pos] = lag_tables[g][ring_pos] + lag_tables[g][ahead];
         mixed ^= lag_tables[g][ring_pos];
      end
      ring_pos = (int'(ring_pos) == LONG_LAG - 1) ? '0 : ring_pos + 1'b1;
      return mixed;
   endfunction

   // Apply one accepted request to the predictor; a generate yields a fraction
   // with the first step in the low word.
   function automatic bit predict_fraction(input logic cmd, input sel_type sel,
                                           input idx_type slot, input word_type word,
                                           output frac_type fraction);
      word_type low_word;
      fraction = '0;
      if (cmd == CMD_LOAD) begin
         if (int'(sel) < GEN_COUNT && int'(slot) < LONG_LAG)
            lag_tables[sel][slot] = word;
         return 1'b0;
      end
      low_word = lag_xor_step();
      fraction = {lag_xor_step(), low_word};
      return 1'b1;
   endfunction

   // Offer one request, hold it through any stall, and record the expectation
   // at the edge that accepts it.
   task automatic send_request(input logic cmd, input sel_type sel, input idx_type slot,
                               input word_type word, input logic typed,
                               input frac_type typed_fraction);
      int       gap;
      frac_type predicted;
      gap = 0;
      if (!quiet_tail && !pressure_on && $urandom_range(0, 5) == 0)
         gap = $urandom_range(1, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_gen_select <= sel;
      req_slot       <= slot;
      req_seed_word  <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      accepted_count++;
      if (predict_fraction(cmd, sel, slot, word, predicted)) begin
         expected_fractions.push_back(typed ? typed_fraction : predicted);
      end else begin
         load_count++;
         if (!(int'(sel) < GEN_COUNT && int'(slot) < LONG_LAG)) dropped_count++;
      end
   endtask

   // Fill every slot of every table so no generate reads an unwritten entry.
   task automatic seed_all_tables(input bit random_words);
      word_type word;
      for (int g = 0; g < GEN_COUNT; g++) begin
         for (int s = 0; s < LONG_LAG; s++) begin
            word = '0;
            if (random_words) begin
               case ($urandom_range(0, 15))
                  0:       word = '0;
                  1:       word = '1;
                  default: word = $urandom;
               endcase
            end
            send_request(CMD_LOAD, sel_type'(g), idx_type'(s), word, 1'b0, '0);
         end
      end
   endtask

   // Stimulus: seed, directed table, reseed at random, then the random stream.
   initial begin
      logic     cmd;
      sel_type  sel;
      idx_type  slot;
      word_type word;
      int       pick;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_cmd        <= CMD_LOAD;
      req_gen_select <= SEL_ONE;
      req_slot       <= '0;
      req_seed_word  <= '0;
      quiet_tail     = 1'b0;
      error_count    = 0;
      accepted_count = 0;
      load_count     = 0;
      dropped_count  = 0;
      checked_count  = 0;
      ring_pos       = '0;
      for (int g = 0; g < GEN_COUNT; g++)
         for (int s = 0; s < LONG_LAG; s++)
            lag_tables[g][s] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      seed_all_tables(1'b0);
      for (int r = 0; r < DIRECTED_ROWS; r++)
         send_request(DIRECTED_TABLE[r].cmd, DIRECTED_TABLE[r].sel, DIRECTED_TABLE[r].slot,
                      DIRECTED_TABLE[r].word, DIRECTED_TABLE[r].typed,
                      DIRECTED_TABLE[r].fraction);
      seed_all_tables(1'b1);

      // Mostly generates and valid loads; a share of dropped loads as noise.
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n >= RANDOM_REQUESTS - QUIET_TAIL) quiet_tail = 1'b1;
         pick = $urandom_range(0, 99);
         word = $urandom;
         sel  = sel_type'($urandom_range(0, 3));
         slot = idx_type'($urandom_range(0, 63));
         if (pick < 50) begin
            cmd = CMD_GEN;
         end else begin
            cmd = CMD_LOAD;
            if (pick < 88) begin
               sel  = sel_type'($urandom_range(0, GEN_COUNT - 1));
               slot = idx_type'($urandom_range(0, LONG_LAG - 1));
               if ($urandom_range(0, 15) == 0) word = $urandom_range(0, 1) ? '1 : '0;
            end else if (pick < 94) begin
               sel = SEL_NONE;
            end else begin
               slot = idx_type'($urandom_range(LONG_LAG, 63));
            end
         end
         send_request(cmd, sel, slot, word, 1'b0, '0);
      end
      req_valid <= 1'b0;

      // Drain outstanding fractions, then let the pipeline settle.
      while (expected_fractions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests: %0d loads (%0d dropped), %0d fractions checked",
               accepted_count, load_count, dropped_count, checked_count);
      $display("Included zero seeding, wrapping sums, bad selects/slots and a long back-pressure hold");
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Receiver: random stall bursts, one long hold-off once enough requests are
   // in, and no stalling in the quiet tail.
   initial begin
      int stall_left;
      bit pressure_done;
      stall_left    = 0;
      pressure_done = 1'b0;
      pressure_on   = 1'b0;
      rsp_stall    <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!pressure_done && accepted_count >= PRESSURE_AT) begin
            // hold long enough that a waiting generate backs up into req_stall
            pressure_done = 1'b1;
            pressure_on   = 1'b1;
            stall_left    = PRESSURE_CYCLES - 1;
            rsp_stall    <= 1'b1;
         end else if (!reset && !quiet_tail && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            rsp_stall <= 1'b1;
         end else begin
            pressure_on = 1'b0;
            rsp_stall  <= 1'b0;
         end
      end
   end

   // Check each accepted fraction against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_fractions.size() == 0) begin
            $display("%0t: unexpected fraction, expected none, actual %h",
                     $time, rsp_fraction);
            error_count++;
         end else begin
            if (rsp_fraction !== expected_fractions[0]) begin
               $display("%0t: fraction mismatch, expected %h, actual %h",
                        $time, expected_fractions[0], rsp_fraction);
               error_count++;
            end
            void'(expected_fractions.pop_front());
            checked_count++;
         end
      end
   end

endmodule

// File: filelist.f
rtl/talx_pkg.sv
rtl/triple_additive_lfg_xor.sv
rtl/talx_check.sv
tb/tb_triple_additive_lfg_xor.sv
